// ----- rtl/core/spq_pkg.sv -----
`timescale 1ns / 1ps

package spq_pkg;

	// Default configuration of the queue.
	localparam int DefDepth      = 16;
	localparam int DefValueWidth = 32;
	localparam int DefPrioWidth  = 8;

	// Request kinds carried on the slave-side tuser.
	localparam logic ReqInsert = 1'b0;
	localparam logic ReqRemove = 1'b1;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic ins;
		logic rem;
	} spq_cmd_t;

	// Status flags of one result; the lowest bit is accepted.
	typedef struct packed {
		logic head_valid;
		logic empty_miss;
		logic full_drop;
		logic accepted;
	} spq_flags_t;

endpackage

// ----- rtl/core/spq_cell.sv -----
`timescale 1ns / 1ps

module spq_cell import spq_pkg::*; #(
	parameter int VALUE_WIDTH = DefValueWidth,
	parameter int PRIO_WIDTH  = DefPrioWidth,
	parameter int CNT_W       = $clog2(DefDepth + 1),
	parameter int IDX         = 0
) (
	input  logic                   clk,
	input  spq_cmd_t               cmd,
	input  logic [CNT_W-1:0]       cnt,
	input  logic [VALUE_WIDTH-1:0] in_value,
	input  logic [PRIO_WIDTH-1:0]  in_prio,
	input  logic                   left_keep,
	input  logic [VALUE_WIDTH-1:0] left_value,
	input  logic [PRIO_WIDTH-1:0]  left_prio,
	input  logic [VALUE_WIDTH-1:0] right_value,
	input  logic [PRIO_WIDTH-1:0]  right_prio,
	output logic                   keep,
	output logic [VALUE_WIDTH-1:0] value_q,
	output logic [PRIO_WIDTH-1:0]  prio_q
);

	logic occupied;

	// The cell holds an entry when its slot lies below the count.
	assign occupied = (CNT_W'(IDX) < cnt);

	// An occupied entry of greater or equal priority stays ahead of a newcomer.
	assign keep = occupied && (prio_q >= in_prio);

	// Insert: hold, take the newcomer, or take the left neighbor's entry.
	// Remove: take the right neighbor's entry.
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (!keep) begin
				if (left_keep) begin
					value_q <= in_value;
					prio_q  <= in_prio;
				end else begin
					value_q <= left_value;
					prio_q  <= left_prio;
				end
			end
		end else if (cmd.rem) begin
			value_q <= right_value;
			prio_q  <= right_prio;
		end
	end

endmodule

// ----- rtl/core/spq_result_reg.sv -----
`timescale 1ns / 1ps

module spq_result_reg import spq_pkg::*; #(
	parameter int VALUE_WIDTH = DefValueWidth,
	parameter int PRIO_WIDTH  = DefPrioWidth,
	parameter int CNT_W       = $clog2(DefDepth + 1),
	parameter int M_DATA_W    = ((VALUE_WIDTH + PRIO_WIDTH + CNT_W + 7) / 8) * 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  spq_flags_t             flags,
	input  logic [VALUE_WIDTH-1:0] head_value,
	input  logic [PRIO_WIDTH-1:0]  head_prio,
	input  logic [CNT_W-1:0]       count,
	output logic                   ready,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// Fields from bit 0 up: head_value, head_priority, entry_count, zero fill.
	output logic [M_DATA_W-1:0]    m_tdata,
	// Fields from bit 0 up: accepted, full_drop, empty_miss, head_valid.
	output logic [3:0]             m_tuser
);

	localparam int PadW = M_DATA_W - VALUE_WIDTH - PRIO_WIDTH - CNT_W;

	logic                   valid_q;
	spq_flags_t             flags_q;
	logic [VALUE_WIDTH-1:0] value_q;
	logic [PRIO_WIDTH-1:0]  prio_q;
	logic [CNT_W-1:0]       count_q;

	// A new result may be loaded when the register is empty or drains now.
	assign ready = !valid_q || m_tready;

	// Valid flag of the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= load;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (load && ready) begin
			flags_q <= flags;
			value_q <= head_value;
			prio_q  <= head_prio;
			count_q <= count;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tuser  = flags_q;
	assign m_tdata  = {{PadW{1'b0}}, count_q, prio_q, value_q};

endmodule

// ----- rtl/core/stable_priority_queue_core.sv -----
`timescale 1ns / 1ps
// A request's result appears on the master side in the cycle after its transfer.
// Throughput: one request per cycle while the master side takes results; every cell
// of the chain updates in the same cycle as its neighbors.
// Reset: arst_n clears the entry count and the output valid flag; the cell
// contents are left as they are and are never read until written.

module stable_priority_queue_core import spq_pkg::*; #(
	parameter int DEPTH       = DefDepth,
	parameter int VALUE_WIDTH = DefValueWidth,
	parameter int PRIO_WIDTH  = DefPrioWidth,
	parameter int CNT_W       = $clog2(DEPTH + 1),
	parameter int S_DATA_W    = ((VALUE_WIDTH + PRIO_WIDTH + 7) / 8) * 8,
	parameter int M_DATA_W    = ((VALUE_WIDTH + PRIO_WIDTH + CNT_W + 7) / 8) * 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// Fields from bit 0 up: item_value, item_priority, zero fill.
	input  logic [S_DATA_W-1:0] s_tdata,
	// Fields from bit 0 up: req_type.
	input  logic                s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// Fields from bit 0 up: head_value, head_priority, entry_count, zero fill.
	output logic [M_DATA_W-1:0] m_tdata,
	// Fields from bit 0 up: accepted, full_drop, empty_miss, head_valid.
	output logic [3:0]          m_tuser
);

	logic                   xfer;
	logic [VALUE_WIDTH-1:0] in_value;
	logic [PRIO_WIDTH-1:0]  in_prio;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       count_n;
	logic                   full;
	logic                   empty;
	spq_cmd_t               cmd;
	spq_flags_t             flags;
	logic [VALUE_WIDTH-1:0] head_value;
	logic [PRIO_WIDTH-1:0]  head_prio;

	logic [VALUE_WIDTH-1:0] value_a [DEPTH];
	logic [PRIO_WIDTH-1:0]  prio_a  [DEPTH];
	logic                   keep_a  [DEPTH];

	assign in_value = s_tdata[VALUE_WIDTH-1:0];
	assign in_prio  = s_tdata[VALUE_WIDTH +: PRIO_WIDTH];
	assign xfer     = s_tvalid && s_tready;
	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);

	// Decode the request into the command for the cells.
	always_comb begin
		cmd.ins = xfer && (s_tuser == ReqInsert) && !full;
		cmd.rem = xfer && (s_tuser == ReqRemove) && !empty;
	end

	// Entry count after the request.
	always_comb begin
		count_n = count_q;
		if (cmd.ins) begin
			count_n = count_q + CNT_W'(1);
		end else if (cmd.rem) begin
			count_n = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_n;
		end
	end

	// Chain of cells, head at cell 0.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                   left_keep;
		logic [VALUE_WIDTH-1:0] left_value;
		logic [PRIO_WIDTH-1:0]  left_prio;
		logic [VALUE_WIDTH-1:0] right_value;
		logic [PRIO_WIDTH-1:0]  right_prio;

		if (i == 0) begin : g_first
			assign left_keep  = 1'b1;
			assign left_value = in_value;
			assign left_prio  = in_prio;
		end else begin : g_inner_left
			assign left_keep  = keep_a[i-1];
			assign left_value = value_a[i-1];
			assign left_prio  = prio_a[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_value = value_a[i];
			assign right_prio  = prio_a[i];
		end else begin : g_inner_right
			assign right_value = value_a[i+1];
			assign right_prio  = prio_a[i+1];
		end

		spq_cell #(
			.VALUE_WIDTH(VALUE_WIDTH),
			.PRIO_WIDTH (PRIO_WIDTH),
			.CNT_W      (CNT_W),
			.IDX        (i)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.cnt        (count_q),
			.in_value   (in_value),
			.in_prio    (in_prio),
			.left_keep  (left_keep),
			.left_value (left_value),
			.left_prio  (left_prio),
			.right_value(right_value),
			.right_prio (right_prio),
			.keep       (keep_a[i]),
			.value_q    (value_a[i]),
			.prio_q     (prio_a[i])
		);
	end

	// Head entry after the request, zero when the queue ends up empty.
	always_comb begin
		head_value = value_a[0];
		head_prio  = prio_a[0];
		if (cmd.ins && !keep_a[0]) begin
			head_value = in_value;
			head_prio  = in_prio;
		end else if (cmd.rem) begin
			head_value = value_a[1];
			head_prio  = prio_a[1];
		end
		if (count_n == '0) begin
			head_value = '0;
			head_prio  = '0;
		end
	end

	// Status flags of the result.
	always_comb begin
		flags.accepted   = cmd.ins || cmd.rem;
		flags.full_drop  = xfer && (s_tuser == ReqInsert) && full;
		flags.empty_miss = xfer && (s_tuser == ReqRemove) && empty;
		flags.head_valid = (count_n != '0);
	end

	spq_result_reg #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.PRIO_WIDTH (PRIO_WIDTH),
		.CNT_W      (CNT_W),
		.M_DATA_W   (M_DATA_W)
	) u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (xfer),
		.flags     (flags),
		.head_value(head_value),
		.head_prio (head_prio),
		.count     (count_n),
		.ready     (s_tready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// The count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above capacity");

	// The two front entries stay in priority order.
	a_head_order: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(2)) |-> (prio_a[0] >= prio_a[1]))
		else $error("front entries out of order");

	// An insert into a full queue leaves the count unchanged and is flagged.
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && (s_tuser == ReqInsert) && full) |=>
		(count_q == CNT_W'(DEPTH)) && m_tvalid && m_tuser[1])
		else $error("full insert not dropped");

	// A remove from a non-empty queue lowers the count by one.
	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rem |=> (count_q == $past(count_q) - CNT_W'(1)))
		else $error("remove did not lower the count");

endmodule
